/* rtl/timestamp_exchange_sorter_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef TIMESTAMP_EXCHANGE_SORTER_CORE_ASSERT_SVH
`define TIMESTAMP_EXCHANGE_SORTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tes_pkg.sv */
package tes_pkg;

    // Capacity of the record store.
    localparam int MAX_ITEMS = 64;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_W     = 64;
    localparam int TAG_W     = 16;

    // One stored record: key and tag travel together.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT_RD,
        S_SORT_CUR,
        S_SORT_SCAN,
        S_SORT_WB,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_WAIT
    } t_state;

endpackage

/* rtl/tes_ram.sv */
module tes_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tes_pkg::ADDR_W-1:0] i_waddr,
    input  tes_pkg::t_rec              i_wdata,
    input  logic                       i_re,
    input  logic [tes_pkg::ADDR_W-1:0] i_raddr,
    output tes_pkg::t_rec              o_rdata
);

    tes_pkg::t_rec r_mem [tes_pkg::MAX_ITEMS];
    tes_pkg::t_rec r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/timestamp_exchange_sorter_core.sv */
// Channel  | Direction | Handshake                | Payload
// input    | in        | i_in_valid / o_in_ready  | i_time_key, i_item_tag, i_load_last
// output   | out       | o_out_valid / i_out_ready| o_sorted_key, o_sorted_tag,
//          |           |                          | o_emit_last, o_overflowed
//
// Loading takes one cycle per record; the record marked last starts the sort.
// Sorting a batch of n >= 2 records makes one store read per compare in the scan
// loop, plus one load and one write-back per pass.
// A batch of one record skips the sort. Emission steps through read, capture and
// handshake for each record in turn.
// Reset is synchronous and active low; the store needs no clearing pass.
// A stalled output holds the sequencer; no input is taken until emission ends.
module timestamp_exchange_sorter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [tes_pkg::KEY_W-1:0]  i_time_key,
    input  logic        [tes_pkg::TAG_W-1:0]  i_item_tag,
    input  logic                              i_load_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tes_pkg::KEY_W-1:0]  o_sorted_key,
    output logic        [tes_pkg::TAG_W-1:0]  o_sorted_tag,
    output logic                              o_emit_last,
    output logic                              o_overflowed
);

    localparam int AW = tes_pkg::ADDR_W;
    localparam int CW = tes_pkg::CNT_W;

    tes_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_fill, n_fill;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_last, n_last;
    tes_pkg::t_rec r_cur, n_cur;

    logic          r_out_valid, n_out_valid;
    tes_pkg::t_rec r_out_rec, n_out_rec;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    tes_pkg::t_rec mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    tes_pkg::t_rec mem_rdata;

    logic          in_fire;
    logic          store_full;
    logic [CW-1:0] fill_after;
    logic          key_less;

    tes_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_ready = (r_state == tes_pkg::S_LOAD);
    assign in_fire    = i_in_valid && o_in_ready;
    assign store_full = (r_fill == CW'(tes_pkg::MAX_ITEMS));
    assign fill_after = store_full ? r_fill : r_fill + CW'(1);
    assign key_less   = $signed(mem_rdata.key) < $signed(r_cur.key);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tes_pkg::S_LOAD: begin
                if (in_fire && i_load_last) begin
                    n_state = (fill_after == CW'(1)) ? tes_pkg::S_EMIT_RD
                                                     : tes_pkg::S_SORT_RD;
                end
            end
            tes_pkg::S_SORT_RD:  n_state = tes_pkg::S_SORT_CUR;
            tes_pkg::S_SORT_CUR: n_state = tes_pkg::S_SORT_SCAN;
            tes_pkg::S_SORT_SCAN: begin
                if (r_j == r_last) begin
                    n_state = tes_pkg::S_SORT_WB;
                end
            end
            tes_pkg::S_SORT_WB: begin
                n_state = (r_i + AW'(1) == r_last) ? tes_pkg::S_EMIT_RD
                                                   : tes_pkg::S_SORT_CUR;
            end
            tes_pkg::S_EMIT_RD:  n_state = tes_pkg::S_EMIT_CAP;
            tes_pkg::S_EMIT_CAP: n_state = tes_pkg::S_EMIT_WAIT;
            tes_pkg::S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_state = (r_k == r_last) ? tes_pkg::S_LOAD : tes_pkg::S_EMIT_RD;
                end
            end
            default: n_state = tes_pkg::S_LOAD;
        endcase
    end

    // Store accesses, counters and output register per state.
    always_comb begin
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_last      = r_last;
        n_cur       = r_cur;
        n_out_valid = r_out_valid;
        n_out_rec   = r_out_rec;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mem_we      = 1'b0;
        mem_waddr   = r_i;
        mem_wdata   = r_cur;
        mem_re      = 1'b0;
        mem_raddr   = r_i;
        unique case (r_state)
            tes_pkg::S_LOAD: begin
                // Store the request, or mark the batch as overflowed.
                if (in_fire) begin
                    if (store_full) begin
                        n_drop = 1'b1;
                    end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_fill[AW-1:0];
                        mem_wdata.key = i_time_key;
                        mem_wdata.tag = i_item_tag;
                        n_fill        = fill_after;
                    end
                    if (i_load_last) begin
                        n_last = AW'(fill_after - CW'(1));
                        n_i    = '0;
                        n_k    = '0;
                    end
                end
            end
            tes_pkg::S_SORT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_i;
            end
            tes_pkg::S_SORT_CUR: begin
                // Hold the record at the outer position, start the scan.
                n_cur     = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_i + AW'(1);
                n_j       = r_i + AW'(1);
            end
            tes_pkg::S_SORT_SCAN: begin
                // A strictly smaller key swaps with the held record.
                if (key_less) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_j;
                    mem_wdata = r_cur;
                    n_cur     = mem_rdata;
                end
                if (r_j != r_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j + AW'(1);
                    n_j       = r_j + AW'(1);
                end
            end
            tes_pkg::S_SORT_WB: begin
                // Write back the minimum and fetch the next outer record.
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_cur;
                mem_re    = 1'b1;
                mem_raddr = r_i + AW'(1);
                n_i       = r_i + AW'(1);
            end
            tes_pkg::S_EMIT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_k;
            end
            tes_pkg::S_EMIT_CAP: begin
                n_out_valid = 1'b1;
                n_out_rec   = mem_rdata;
                n_out_last  = (r_k == r_last);
                n_out_ovf   = r_drop;
            end
            tes_pkg::S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_k == r_last) begin
                        n_fill = '0;
                        n_drop = 1'b0;
                        n_i    = '0;
                        n_k    = '0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tes_pkg::S_LOAD;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_out_rec  <= n_out_rec;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out_rec.key;
    assign o_sorted_tag = r_out_rec.tag;
    assign o_emit_last  = r_out_last;
    assign o_overflowed = r_out_ovf;

endmodule

/* rtl/tes_checker.sv */
`include "timestamp_exchange_sorter_core_assert.svh"

module tes_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        i_load_last,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [tes_pkg::KEY_W-1:0]   o_sorted_key,
    input logic                        o_emit_last
);

    // Loading and emission never overlap.
    `TES_ASSERT_NOW(a_no_load_while_emit, i_clk, i_rst_n, o_out_valid, !o_in_ready, "input ready during emission")

    // The last record of a batch closes the input side.
    `TES_ASSERT_NEXT(a_last_closes_input, i_clk, i_rst_n, i_in_valid && o_in_ready && i_load_last, !o_in_ready, "input still open after last record")

    // After the final result is taken, no result follows at once.
    `TES_ASSERT_NEXT(a_burst_ends, i_clk, i_rst_n, o_out_valid && i_out_ready && o_emit_last, !o_out_valid, "result after final record")

    // A stalled result keeps its key.
    `TES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sorted_key), "stalled result changed")

endmodule

bind timestamp_exchange_sorter_core tes_checker u_tes_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_load_last  (i_load_last),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_sorted_key (o_sorted_key),
    .o_emit_last  (o_emit_last)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import tes_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int CYCLE_CAP  = 500000;
    localparam int DRAIN_WAIT = 100;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    // How the keys of a batch are spread out.
    typedef enum int {
        KEYS_WIDE,
        KEYS_CLUSTERED,
        KEYS_EXTREME
    } key_spread_t;

    // One sorted record as it should leave the block.
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last;
        logic                    ovf;
    } sorted_rec_t;

    // Keeps a private copy of the batch store, sorts it the same way the
    // block does, and holds the records still owed by the block.
    class sort_scoreboard;
        logic signed [KEY_W-1:0] key_mem[MAX_ITEMS];
        logic [TAG_W-1:0]        tag_mem[MAX_ITEMS];
        int unsigned             fill;
        bit                      dropped;
        sorted_rec_t             pending_out[$];
        int unsigned             mismatch_count;

        function new();
            fill = 0;
            dropped = 1'b0;
            mismatch_count = 0;
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Store or drop the request; the final one sorts and queues the batch.
        function void note_request(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                   logic last);
            logic signed [KEY_W-1:0] k_hold;
            logic [TAG_W-1:0]        t_hold;
            sorted_rec_t             rec;
            if (fill < MAX_ITEMS) begin
                key_mem[fill] = key;
                tag_mem[fill] = tag;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) return;

            // Exchange sort: each later, strictly smaller key swaps with position i.
            for (int i = 0; i < fill; i++) begin
                for (int j = i + 1; j < fill; j++) begin
                    if (key_mem[j] < key_mem[i]) begin
                        k_hold = key_mem[i];
                        t_hold = tag_mem[i];
                        key_mem[i] = key_mem[j];
                        tag_mem[i] = tag_mem[j];
                        key_mem[j] = k_hold;
                        tag_mem[j] = t_hold;
                    end
                end
            end
            for (int i = 0; i < fill; i++) begin
                rec.key  = key_mem[i];
                rec.tag  = tag_mem[i];
                rec.last = (i == fill - 1);
                rec.ovf  = dropped;
                pending_out.push_back(rec);
            end
            fill = 0;
            dropped = 1'b0;
        endfunction

        // Compare one emitted record with the oldest one owed.
        task check_result(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                          logic last, logic ovf);
            sorted_rec_t want;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("unexpected record key=%0d tag=%h", key, tag));
                return;
            end
            want = pending_out.pop_front();
            if (key !== want.key)
                report_mismatch($sformatf("key %0d, wanted %0d", key, want.key));
            if (tag !== want.tag)
                report_mismatch($sformatf("tag %h, wanted %h", tag, want.tag));
            if (last !== want.last)
                report_mismatch($sformatf("emit_last %b, wanted %b", last, want.last));
            if (ovf !== want.ovf)
                report_mismatch($sformatf("overflowed %b, wanted %b", ovf, want.ovf));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [KEY_W-1:0] i_time_key = '0;
    logic [TAG_W-1:0]        i_item_tag = '0;
    logic                    i_load_last = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [KEY_W-1:0] o_sorted_key;
    logic [TAG_W-1:0]        o_sorted_tag;
    logic                    o_emit_last;
    logic                    o_overflowed;

    sort_scoreboard sb = new();
    bit             calm_phase = 1'b0;
    int unsigned    requests_sent = 0;
    int unsigned    cycle_count = 0;
    int unsigned    stall_left = 0;

    timestamp_exchange_sorter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_time_key  (i_time_key),
        .i_item_tag  (i_item_tag),
        .i_load_last (i_load_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sorted_key(o_sorted_key),
        .o_sorted_tag(o_sorted_tag),
        .o_emit_last (o_emit_last),
        .o_overflowed(o_overflowed)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL timestamp_exchange_sorter_core");
            $finish;
        end
    end

    // Output backpressure in random bursts, none once the run is calm.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Every accepted output record is checked against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_sorted_key, o_sorted_tag, o_emit_last, o_overflowed);
    end

    // Drive one request and wait until it is accepted; valid stays high afterward.
    task send_request(logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_time_key  <= key;
        i_item_tag  <= tag;
        i_load_last <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(key, tag, last);
        requests_sent++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key(key_spread_t spread);
        logic signed [KEY_W-1:0] v;
        case (spread)
            KEYS_CLUSTERED: begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            KEYS_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = KEY_MIN;
                    1:       v = KEY_MAX;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // A batch of random records, the final one marked last. Keys mostly follow
    // the batch spread, with a few strays drawn from any spread.
    task send_batch(int count, key_spread_t spread);
        key_spread_t s;
        for (int i = 0; i < count; i++) begin
            s = ($urandom_range(0, 5) == 0) ? key_spread_t'($urandom_range(0, 2)) : spread;
            send_request(pick_key(s), TAG_W'($urandom_range(0, 65535)), i == count - 1);
        end
    endtask

    initial begin
        int batch_no;
        int n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single-record batches at both ends of the key and tag ranges.
        send_request(KEY_MIN, 16'h0000, 1'b1);
        send_request(KEY_MAX, 16'hFFFF, 1'b1);

        // Mixed extremes around zero.
        send_request(KEY_MAX, 16'h0001, 1'b0);
        send_request(KEY_MIN, 16'h0002, 1'b0);
        send_request('0, 16'h0003, 1'b0);
        send_request('1, 16'h0004, 1'b0);
        send_request(64'sd1, 16'h0005, 1'b0);
        send_request(KEY_MIN + 1, 16'h0006, 1'b1);

        // Repeated keys, so the swap sequence decides the order of equal keys.
        send_request(64'sd5, 16'h0011, 1'b0);
        send_request(64'sd5, 16'h0012, 1'b0);
        send_request(-64'sd3, 16'h0013, 1'b0);
        send_request(64'sd5, 16'h0014, 1'b0);
        send_request(-64'sd3, 16'h0015, 1'b0);
        send_request(64'sd7, 16'h0016, 1'b0);
        send_request(64'sd5, 16'h0017, 1'b0);
        send_request(-64'sd3, 16'h0018, 1'b1);

        // Strictly descending keys, then all keys equal.
        for (int i = 0; i < 5; i++)
            send_request(64'sd100 - 64'(i * 30), 16'h0020 + 16'(i), i == 4);
        send_request(64'sd42, 16'hA5A5, 1'b0);
        send_request(64'sd42, 16'h5A5A, 1'b0);
        send_request(64'sd42, 16'hFFFE, 1'b1);

        // Random batches. A few large ones fill the store exactly, drop the
        // record marked last, and drop several records before the last.
        batch_no = 0;
        while (requests_sent < 520) begin
            if (requests_sent >= 460)
                calm_phase = 1'b1;
            if (batch_no == 8) begin
                send_batch(MAX_ITEMS, KEYS_WIDE);
            end else if (batch_no == 20) begin
                send_batch(MAX_ITEMS + 1, KEYS_CLUSTERED);
            end else if (batch_no == 32) begin
                send_batch(MAX_ITEMS + 4, KEYS_WIDE);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                send_batch(n, key_spread_t'($urandom_range(0, 2)));
            end
            batch_no++;
        end
        i_in_valid <= 1'b0;

        // Drain the remaining records, then watch for strays.
        while (sb.pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatch_count == 0) begin
            $display("PASS timestamp_exchange_sorter_core");
        end else begin
            $display("FAIL timestamp_exchange_sorter_core");
        end
        $finish;
    end

endmodule
